// ===== design/line_rasterizer_macros.svh =====
// -----------------------------------------------------------------------------
// line_rasterizer_macros.svh
// Assertion macros used by the line rasterizer checker.
// -----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define LR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_rasterizer assertion failed");

// Next-cycle implication under a synchronous active-low reset.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_rasterizer assertion failed");

`endif

// ===== design/lrast_pkg.sv =====
// -----------------------------------------------------------------------------
// lrast_pkg
// Types and constants shared by the line rasterizer modules.
// -----------------------------------------------------------------------------
package lrast_pkg;

  localparam int COORD_BITS = 6;
  // Error term needs room for twice a coordinate span plus sign.
  localparam int ERR_W = COORD_BITS + 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic cap;
  } ctl_sts_t;

endpackage

// ===== design/lrast_ctrl.sv =====
// -----------------------------------------------------------------------------
// lrast_ctrl
// Sequencer for the line walk: load, error-term setup, one pixel per beat.
// -----------------------------------------------------------------------------
module lrast_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lrast_pkg::ctl_sts_t sts,
  output lrast_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (out_ready) begin
          if (sts.done || sts.cap) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_WALK);

endmodule

// ===== design/lrast_dp.sv =====
// -----------------------------------------------------------------------------
// lrast_dp
// Coordinate and error-term registers of the Bresenham walk.
// -----------------------------------------------------------------------------
module lrast_dp (
  input  logic                clk,
  input  lrast_pkg::in_t      in_data,
  input  lrast_pkg::ctl_cmd_t cmd,
  output lrast_pkg::ctl_sts_t sts,
  output lrast_pkg::out_t     out_data
);

  localparam int CB = lrast_pkg::COORD_BITS;
  localparam int EW = lrast_pkg::ERR_W;

  logic [CB-1:0]        cx_r, cy_r, tx_r, ty_r;
  logic [CB-1:0]        cx_nxt, cy_nxt;
  logic [CB-1:0]        dx_r;
  logic signed [EW-1:0] ndy_r;
  logic signed [EW-1:0] err_r, err_nxt;
  logic                 sx_neg_r, sy_neg_r;
  logic [CB-1:0]        cnt_r;

  logic [CB-1:0]        dx_abs, dy_abs;
  logic signed [EW-1:0] dx_ext, ndy_set, t_val;

  assign dx_abs  = (tx_r > cx_r) ? (tx_r - cx_r) : (cx_r - tx_r);
  assign dy_abs  = (ty_r > cy_r) ? (ty_r - cy_r) : (cy_r - ty_r);
  assign ndy_set = -$signed({{(EW-CB){1'b0}}, dy_abs});
  assign dx_ext  = $signed({{(EW-CB){1'b0}}, dx_r});
  assign t_val   = err_r <<< 1;

  always_comb begin
    err_nxt = err_r;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    if (t_val >= ndy_r) begin
      err_nxt = err_nxt + ndy_r;
      cx_nxt  = sx_neg_r ? (cx_r - CB'(1)) : (cx_r + CB'(1));
    end
    if (t_val <= dx_ext) begin
      err_nxt = err_nxt + dx_ext;
      cy_nxt  = sy_neg_r ? (cy_r - CB'(1)) : (cy_r + CB'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_data.start_x;
      cy_r <= in_data.start_y;
      tx_r <= in_data.end_x;
      ty_r <= in_data.end_y;
    end else if (cmd.setup) begin
      dx_r     <= dx_abs;
      ndy_r    <= ndy_set;
      err_r    <= $signed({{(EW-CB){1'b0}}, dx_abs}) + ndy_set;
      sx_neg_r <= !(cx_r < tx_r);
      sy_neg_r <= !(cy_r < ty_r);
      cnt_r    <= '0;
    end else if (cmd.step) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r + CB'(1);
    end
  end

  assign sts.done            = (cx_r == tx_r) && (cy_r == ty_r);
  assign sts.cap             = &cnt_r;
  assign out_data.pixel_x    = cx_r;
  assign out_data.pixel_y    = cy_r;
  assign out_data.last_pixel = sts.done;

endmodule

// ===== design/line_rasterizer.sv =====
// -----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line walk over a square tile: one segment in, one beat per pixel.
// -----------------------------------------------------------------------------
//   channel | direction | payload                          | handshake
//   in_     | input     | start_x, start_y, end_x, end_y   | in_valid / in_ready
//   out_    | output    | pixel_x, pixel_y, last_pixel     | out_valid / out_ready
//
// A segment is loaded, its error term is set up, and the walk register then
// delivers one pixel beat per cycle while out_ready is high. Stalls on
// out_ready hold the current pixel. Reset is synchronous and returns the
// sequencer to idle; a new segment is taken only once the
// last pixel of the previous one has been delivered.
// -----------------------------------------------------------------------------
module line_rasterizer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lrast_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lrast_pkg::out_t out_data
);

  lrast_pkg::ctl_cmd_t cmd;
  lrast_pkg::ctl_sts_t sts;

  lrast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrast_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== design/lrast_checker.sv =====
// -----------------------------------------------------------------------------
// lrast_checker
// Port-level checks of the line rasterizer, bound to the top level.
// -----------------------------------------------------------------------------
`include "line_rasterizer_macros.svh"

module lrast_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lrast_pkg::out_t out_data
);

  logic out_last_beat;

  assign out_last_beat = out_valid && out_ready && out_data.last_pixel;

  `LR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `LR_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  `LR_ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `LR_ASSERT_IMPLY(a_first_pixel, clk, rst_n, in_valid && in_ready, ##2 out_valid)
  `LR_ASSERT_NEXT(a_end_after_last, clk, rst_n, out_last_beat, !out_valid && in_ready)

endmodule

bind line_rasterizer lrast_checker u_lrast_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
